FILE: src/mbbc_pkg.sv
package mbbc_pkg;

	localparam int unsigned MAX_DIM_DEFAULT = 2048;

	localparam int unsigned CFG_W     = 12;
	localparam int unsigned PIXEL_W   = 8;
	localparam int unsigned HIT_W     = 23;
	localparam int unsigned CENTER_W  = 12;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned IN_DATA_W = 8;
	localparam int unsigned OUT_DATA_W = 56;

	localparam logic [PIXEL_W-1:0] HIT_VALUE = 8'hFF;
	localparam logic [HIT_W-1:0]   HIT_MAX   = {HIT_W{1'b1}};

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_NONE   = 2'd0,
		STATUS_SINGLE = 2'd1,
		STATUS_BLOB   = 2'd2
	} status_t;

endpackage

FILE: src/mask_blob_bounding_box_center.sv
// mask blob bounding box center
//
// s_* channel: one mask pixel per transaction in raster order (row 0 first,
// column 0 first in a row). a pixel equal to 255 is a hit; hits are counted
// and widen a running bounding box of the frame.
// m_* channel: one result transaction per frame, produced by the frame's
// last pixel: status, hit count and doubled box center (xmin+xmax,
// ymin+ymax), zero center when the frame had no hit.
// cfg_*: frame width (index 0) and height (index 1), written while idle;
// zero reads as 1, values above MAX_DIM read as MAX_DIM.
// throughput: one pixel per clock, set by the single registered update of
// the counters and box registers, except while a frame's last pixel waits
// on a pending result. latency: the result is valid in the cycle after the
// last pixel of the frame is taken. reset: frame size returns to 640 x 480,
// position, box and count are cleared, no result is pending.
// stall: the result sits in the output register; pixels keep flowing, and
// only the last pixel of the next frame waits until that result is taken.
module mask_blob_bounding_box_center #(
	parameter int unsigned MAX_DIM = mbbc_pkg::MAX_DIM_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mbbc_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] pixel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] status, [24:2] hit_count, [36:25] center_x_doubled,
	// [48:37] center_y_doubled, [55:49] zero
	output logic [mbbc_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_addr,
	input  logic [mbbc_pkg::CFG_W-1:0]          cfg_data
);

	localparam int unsigned POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned DIM_W = ((mbbc_pkg::CFG_W > POS_W) ? mbbc_pkg::CFG_W : POS_W) + 1;
	localparam int unsigned SUM_W = ((POS_W + 1) > mbbc_pkg::CENTER_W) ? (POS_W + 1)
		: mbbc_pkg::CENTER_W;
	localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAX_DIM - 1);
	localparam int unsigned PAD_W = mbbc_pkg::OUT_DATA_W - mbbc_pkg::STATUS_W
		- mbbc_pkg::HIT_W - 2 * mbbc_pkg::CENTER_W;

	logic [mbbc_pkg::CFG_W-1:0] frame_width_q, frame_height_q;
	logic [POS_W-1:0] col_q, row_q;
	logic [POS_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [mbbc_pkg::HIT_W-1:0] hit_total_q;

	logic                          out_valid_q;
	mbbc_pkg::status_t             status_q;
	logic [mbbc_pkg::HIT_W-1:0]    hit_count_q;
	logic [mbbc_pkg::CENTER_W-1:0] cx_q, cy_q;

	logic [DIM_W-1:0] w_lim, h_lim;
	logic             row_end, frame_end, hit, accept;
	logic [POS_W-1:0] x_min_n, x_max_n, y_min_n, y_max_n;
	logic [mbbc_pkg::HIT_W-1:0] hit_total_n;
	logic [SUM_W-1:0] sum_x, sum_y;

	function automatic logic [DIM_W-1:0] dim_limit(input logic [mbbc_pkg::CFG_W-1:0] v);
		logic [DIM_W-1:0] d;
		d = DIM_W'(v);
		if (d == '0) begin
			d = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			d = DIM_W'(MAX_DIM);
		end
		return d - DIM_W'(1);
	endfunction

	// position limits and next frame statistics including the current pixel
	always_comb begin
		w_lim     = dim_limit(frame_width_q);
		h_lim     = dim_limit(frame_height_q);
		row_end   = DIM_W'(col_q) >= w_lim;
		frame_end = row_end && (DIM_W'(row_q) >= h_lim);
		hit       = s_tdata[mbbc_pkg::PIXEL_W-1:0] == mbbc_pkg::HIT_VALUE;

		x_min_n     = x_min_q;
		x_max_n     = x_max_q;
		y_min_n     = y_min_q;
		y_max_n     = y_max_q;
		hit_total_n = hit_total_q;
		if (hit) begin
			if (hit_total_q != mbbc_pkg::HIT_MAX) begin
				hit_total_n = hit_total_q + 1'b1;
			end
			if (col_q < x_min_q) x_min_n = col_q;
			if (col_q > x_max_q) x_max_n = col_q;
			if (row_q < y_min_q) y_min_n = row_q;
			if (row_q > y_max_q) y_max_n = row_q;
		end
		sum_x = SUM_W'(x_min_n) + SUM_W'(x_max_n);
		sum_y = SUM_W'(y_min_n) + SUM_W'(y_max_n);
	end

	// only the frame's last pixel has to wait for a pending result
	assign s_tready = !(out_valid_q && !m_tready && frame_end);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= mbbc_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= mbbc_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				mbbc_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				mbbc_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			x_min_q     <= POS_TOP;
			x_max_q     <= '0;
			y_min_q     <= POS_TOP;
			y_max_q     <= '0;
			hit_total_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q       <= '0;
				row_q       <= '0;
				x_min_q     <= POS_TOP;
				x_max_q     <= '0;
				y_min_q     <= POS_TOP;
				y_max_q     <= '0;
				hit_total_q <= '0;
			end else begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				x_min_q     <= x_min_n;
				x_max_q     <= x_max_n;
				y_min_q     <= y_min_n;
				y_max_q     <= y_max_n;
				hit_total_q <= hit_total_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded by the last pixel of a frame
	always_ff @(posedge clk) begin
		if (accept && frame_end) begin
			hit_count_q <= hit_total_n;
			if (hit_total_n == '0) begin
				status_q <= mbbc_pkg::STATUS_NONE;
				cx_q     <= '0;
				cy_q     <= '0;
			end else begin
				status_q <= (hit_total_n == mbbc_pkg::HIT_W'(1)) ? mbbc_pkg::STATUS_SINGLE
					: mbbc_pkg::STATUS_BLOB;
				cx_q     <= sum_x[mbbc_pkg::CENTER_W-1:0];
				cy_q     <= sum_y[mbbc_pkg::CENTER_W-1:0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, cy_q, cx_q, hit_count_q, status_q};

	a_status_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((status_q == mbbc_pkg::STATUS_NONE) == (hit_count_q == '0)))
		else $error("status none does not match zero hit count");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_q == mbbc_pkg::STATUS_SINGLE) |-> (hit_count_q == mbbc_pkg::HIT_W'(1)))
		else $error("single hit status with other hit count");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a blocked result");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame_end) |=> (col_q == '0 && row_q == '0 && hit_total_q == '0 && m_tvalid))
		else $error("frame end did not restart counters and post a result");

endmodule
